[rtl/core/plst_pkg.sv]
// Package for the positional list store: field widths, request codes and
// the command struct that is broadcast to every storage cell. No dependencies.
`default_nettype none

package plst_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int TYPE_W       = 2;
  localparam int LEN_W        = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_RETRIEVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  slot;   // position - 1
    logic [DATA_W-1:0] word;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/plst_cell.sv]
// One storage cell of the list chain: holds a single entry and takes its
// neighbor's entry on a shift. Depends on plst_pkg.
`default_nettype none

module plst_cell #(
  parameter int IDX = 0
) (
  input  wire                         clk_i,
  input  plst_pkg::cell_cmd_t         cmd_i,
  input  wire [plst_pkg::DATA_W-1:0]  left_i,    // entry of cell IDX-1
  input  wire [plst_pkg::DATA_W-1:0]  right_i,   // entry of cell IDX+1
  output logic [plst_pkg::DATA_W-1:0] word_o,
  output logic [plst_pkg::DATA_W-1:0] rd_word_o  // word when slot matches, else 0
);
  import plst_pkg::*;

  logic [DATA_W-1:0] word_q, word_d;
  logic              at_slot, past_slot;

  assign at_slot   = (int'(cmd_i.slot) == IDX);
  assign past_slot = (IDX > int'(cmd_i.slot));

  always_comb begin
    word_d = word_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (at_slot) begin
          word_d = cmd_i.word;
        end else if (past_slot) begin
          word_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (at_slot || past_slot) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = at_slot ? word_q : '0;

endmodule

`default_nettype wire

[rtl/core/positional_list_store.sv]
// Positional list store, 1-based insert/remove/retrieve over a chain of cells.
// Depends on plst_pkg and plst_cell.
//
// Accepts one request per clock cycle while the result side is not stalled
// and answers each with one result word from an output register; every
// cell of the chain compares its own index with the requested position and
// shifts in parallel, so an insert or remove updates the whole chain at once
// regardless of position. Backpressure on the result side stalls the request
// side only while the output register is full and not being taken. No
// clearing pass after reset; entries beyond the current length are never read.
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // [4:0] position, [36:5] entry_word, rest zero
  input  wire  [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] read_word, [36:32] list_length, rest zero
  output logic [0:0]  m_axis_tuser    // [0] ok
);
  import plst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q;
  logic              ok_q;
  logic [DATA_W-1:0] rd_q;
  logic [LEN_W-1:0]  len_q;

  logic              accept;
  logic [TYPE_W-1:0] req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] entry_word;
  logic [LW-1:0]     pos_ext, cnt_ext, cnt_next_ext;
  logic              pos_nz, ins_ok, pos_ok, req_ok;
  logic [DATA_W-1:0] rd_any, rd_word;
  cell_cmd_t         cmd;

  logic [DATA_W-1:0] cell_word [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign req_type   = s_axis_tuser;
  assign position   = s_axis_tdata[POS_W-1:0];
  assign entry_word = s_axis_tdata[POS_W+DATA_W-1:POS_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_ext = LW'(position);
  assign cnt_ext = LW'(count_q);
  assign pos_nz  = (position != '0);
  assign ins_ok  = pos_nz && (pos_ext <= cnt_ext + LW'(1)) && (count_q < CW'(CAPACITY));
  assign pos_ok  = pos_nz && (pos_ext <= cnt_ext);

  always_comb begin
    req_ok  = 1'b0;
    count_d = count_q;
    cmd.op  = CELL_HOLD;
    unique case (req_type)
      REQ_INSERT: begin
        req_ok = ins_ok;
        if (accept && ins_ok) begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + CW'(1);
        end
      end
      REQ_REMOVE: begin
        req_ok = pos_ok;
        if (accept && pos_ok) begin
          cmd.op  = CELL_REMOVE;
          count_d = count_q - CW'(1);
        end
      end
      REQ_RETRIEVE: req_ok = pos_ok;
      default:      req_ok = 1'b0;
    endcase
    cmd.slot = position - POS_W'(1);
    cmd.word = entry_word;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[k+1];
    end
    plst_cell #(.IDX(k)) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .left_i    (left_w),
      .right_i   (right_w),
      .word_o    (cell_word[k]),
      .rd_word_o (cell_rd[k])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | cell_rd[k];
    end
  end

  assign rd_word      = (req_type == REQ_RETRIEVE && pos_ok) ? rd_any : '0;
  assign cnt_next_ext = LW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q  <= req_ok;
      rd_q  <= rd_word;
      len_q <= cnt_next_ext[LEN_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tdata  = {3'b000, len_q, rd_q};

  // length never exceeds the chain size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  // a successful insert grows the list by exactly one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type == REQ_INSERT && ins_ok) |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the list");

  // a rejected request leaves the length alone
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req_ok) |=> count_q == $past(count_q))
    else $error("rejected request changed the length");

  // failed results carry a zero read word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> rd_q == '0)
    else $error("nonzero read word on failed request");

endmodule

`default_nettype wire
